// ===== rtl/core/nnq_pkg.sv =====
// Shared types and constants of the name query responder.
// No dependencies; imported by the parser, queue, reply generator and top level.
package nnq_pkg;

  localparam int unsigned NAME_BYTES = 32;
  localparam int unsigned NAME_CHARS = 15;
  localparam int unsigned RAM_DEPTH  = 2 * NAME_BYTES;
  localparam int unsigned RAM_AW     = $clog2(RAM_DEPTH);

  // configuration register indexes
  localparam logic [7:0] CFG_NAME_FIRST = 8'd0;
  localparam logic [7:0] CFG_NAME_REST  = 8'd1;
  localparam logic [7:0] CFG_NAME_LEN   = 8'd2;
  localparam logic [7:0] CFG_IP_ADDR    = 8'd3;

  // byte positions, shared by request parsing and reply layout
  localparam logic [5:0] POS_TID_HI    = 6'd0;
  localparam logic [5:0] POS_TID_LO    = 6'd1;
  localparam logic [5:0] POS_FLAGS_HI  = 6'd2;
  localparam logic [5:0] POS_FLAGS_LO  = 6'd3;
  localparam logic [5:0] POS_QDCNT_HI  = 6'd4;
  localparam logic [5:0] POS_QDCNT_LO  = 6'd5;
  localparam logic [5:0] POS_ANCNT_LO  = 6'd7;
  localparam logic [5:0] POS_LABEL     = 6'd12;
  localparam logic [5:0] POS_NAME_LO   = 6'd13;
  localparam logic [5:0] POS_NAME_HI   = 6'd44;
  localparam logic [5:0] POS_CHAR_LAST = 6'd42;
  localparam logic [5:0] POS_QTYPE_HI  = 6'd46;
  localparam logic [5:0] POS_QTYPE_LO  = 6'd47;
  localparam logic [5:0] POS_CLASS_LO  = 6'd49;
  localparam logic [5:0] POS_TTL_1     = 6'd51;
  localparam logic [5:0] POS_TTL_2     = 6'd52;
  localparam logic [5:0] POS_TTL_3     = 6'd53;
  localparam logic [5:0] POS_RDLEN_LO  = 6'd55;
  localparam logic [5:0] POS_IP_0      = 6'd58;
  localparam logic [5:0] POS_IP_1      = 6'd59;
  localparam logic [5:0] POS_IP_2      = 6'd60;
  localparam logic [5:0] POS_IP_3      = 6'd61;
  localparam logic [5:0] POS_REPLY_END = 6'd61;
  localparam logic [5:0] MIN_QUERY_LEN = 6'd50;
  localparam logic [5:0] COUNT_MAX     = 6'd63;

  localparam logic [15:0] FLAG_QR      = 16'h8000;
  localparam logic [15:0] FLAG_OPCODE  = 16'h7800;
  localparam logic [15:0] QTYPE_NB     = 16'h0020;
  localparam logic [7:0]  LABEL_LEN    = 8'h20;
  localparam logic [7:0]  REPLY_FLAGS  = 8'h85;
  localparam logic [7:0]  TTL_1        = 8'h04;
  localparam logic [7:0]  TTL_2        = 8'h93;
  localparam logic [7:0]  TTL_3        = 8'he0;
  localparam logic [7:0]  RDLEN_LO     = 8'h06;
  localparam logic [7:0]  ENC_BASE     = 8'h41;
  localparam logic [7:0]  CHAR_SPACE   = 8'h20;

  typedef struct packed {
    logic        push;
    logic [15:0] tid;
  } nnq_cmd_t;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } nnq_wr_t;

endpackage

// ===== rtl/core/nnq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nnq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/nnq_front.sv =====
// Request parser: header capture, name decode and query check.
// Depends on nnq_pkg; writes encoded names into the name RAM.
module nnq_front import nnq_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  input  logic [119:0]  cfg_name,
  input  logic [3:0]    cfg_name_len,
  input  logic [31:0]   cfg_ip,
  output nnq_cmd_t      cmd,
  output nnq_wr_t       wr
);

  logic [5:0]  cnt_r, cnt_nxt;
  logic        bank_r, bank_nxt;
  logic [15:0] tid_r, flags_r, qdcnt_r, qtype_r;
  logic [7:0]  label_r, hi_r;
  logic [7:0]  raw_r [NAME_CHARS];
  logic [5:0]  name_off;
  logic [5:0]  char_off;
  logic [7:0]  hi_dec, lo_dec;
  logic [5:0]  len_cur;
  logic [3:0]  trim_len;
  logic        mismatch;
  logic        query_ok;
  logic        in_name;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) ? c - 8'h20 : c;
  endfunction

  assign name_off = cnt_r - POS_NAME_LO;
  assign char_off = cnt_r - (POS_NAME_LO + 6'd1);
  assign in_name  = (cnt_r >= POS_NAME_LO) && (cnt_r <= POS_NAME_HI);
  assign hi_dec   = hi_r - ENC_BASE;
  assign lo_dec   = data_byte - ENC_BASE;

  always_ff @(posedge clk) begin
    if (acc && cnt_r != COUNT_MAX) begin
      case (cnt_r) inside
        POS_TID_HI:   tid_r[15:8]   <= data_byte;
        POS_TID_LO:   tid_r[7:0]    <= data_byte;
        POS_FLAGS_HI: flags_r[15:8] <= data_byte;
        POS_FLAGS_LO: flags_r[7:0]  <= data_byte;
        POS_QDCNT_HI: qdcnt_r[15:8] <= data_byte;
        POS_QDCNT_LO: qdcnt_r[7:0]  <= data_byte;
        POS_LABEL:    label_r       <= data_byte;
        POS_QTYPE_HI: qtype_r[15:8] <= data_byte;
        POS_QTYPE_LO: qtype_r[7:0]  <= data_byte;
        default: ;
      endcase
      if (in_name && cnt_r <= POS_CHAR_LAST) begin
        if (!name_off[0]) begin
          hi_r <= data_byte;
        end else begin
          raw_r[char_off[4:1]] <= {hi_dec[3:0], lo_dec[3:0]};
        end
      end
    end
  end

  // trailing-space trim and case-insensitive compare
  always_comb begin
    trim_len = 4'd0;
    mismatch = 1'b0;
    for (int i = 0; i < NAME_CHARS; i++) begin
      if (raw_r[i] != CHAR_SPACE) begin
        trim_len = 4'(i + 1);
      end
      if (4'(i) < cfg_name_len &&
          to_upper(raw_r[i]) != to_upper(cfg_name[8*i +: 8])) begin
        mismatch = 1'b1;
      end
    end
  end

  assign len_cur  = (cnt_r == COUNT_MAX) ? COUNT_MAX : cnt_r + 6'd1;
  assign query_ok = (len_cur >= MIN_QUERY_LEN) &&
                    ((flags_r & FLAG_QR) == 16'h0000) &&
                    ((flags_r & FLAG_OPCODE) == 16'h0000) &&
                    (qdcnt_r != 16'h0000) &&
                    (label_r == LABEL_LEN) &&
                    (qtype_r == QTYPE_NB) &&
                    (cfg_name_len != 4'd0) &&
                    (trim_len == cfg_name_len) &&
                    !mismatch &&
                    (cfg_ip != 32'h0);

  assign cmd.push = acc && last_byte && query_ok;
  assign cmd.tid  = tid_r;

  assign wr.we   = acc && in_name;
  assign wr.addr = {bank_r, name_off[4:0]};
  assign wr.data = data_byte;

  always_comb begin
    cnt_nxt  = cnt_r;
    bank_nxt = bank_r ^ cmd.push;
    if (acc) begin
      if (last_byte) begin
        cnt_nxt = 6'd0;
      end else if (cnt_r != COUNT_MAX) begin
        cnt_nxt = cnt_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 6'd0;
      bank_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      bank_r <= bank_nxt;
    end
  end

endmodule

// ===== rtl/core/nnq_fifo.sv =====
// Two-entry request queue between parser and reply generator.
// Depends on nnq_pkg for the request type.
module nnq_fifo import nnq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  nnq_cmd_t    cmd,
  input  logic        pop,
  output logic [15:0] head_tid,
  output logic        full,
  output logic        empty
);

  logic [15:0] mem_r [2];
  logic [1:0]  count_r, count_nxt;
  logic        wp_r, rp_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign head_tid = mem_r[rp_r];

  always_comb begin
    count_nxt = count_r;
    if (cmd.push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!cmd.push && pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem_r[wp_r] <= cmd.tid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      wp_r    <= wp_r ^ cmd.push;
      rp_r    <= rp_r ^ pop;
    end
  end

endmodule

// ===== rtl/core/nnq_back.sv =====
// Reply generator: walks the 62 response bytes of the head request.
// Depends on nnq_pkg; reads echoed name bytes from the name RAM.
module nnq_back import nnq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_empty,
  input  logic [15:0]       head_tid,
  input  logic [31:0]       cfg_ip,
  input  logic [7:0]        ram_rdata,
  input  logic              out_pop,
  output logic [RAM_AW-1:0] ram_raddr,
  output logic              done,
  output logic [7:0]        reply_byte,
  output logic              reply_last
);

  logic [5:0] k_r, k_nxt;
  logic       bank_r, bank_nxt;
  logic [5:0] name_off;
  logic       fire;

  assign fire     = out_pop && !req_empty;
  assign done     = fire && (k_r == POS_REPLY_END);
  assign k_nxt    = done ? 6'd0 : (fire ? k_r + 6'd1 : k_r);
  assign bank_nxt = bank_r ^ done;
  // address the byte shown next cycle, data lands in time
  assign name_off  = k_nxt - POS_NAME_LO;
  assign ram_raddr = {bank_nxt, name_off[4:0]};

  always_comb begin
    case (k_r) inside
      POS_TID_HI:                 reply_byte = head_tid[15:8];
      POS_TID_LO:                 reply_byte = head_tid[7:0];
      POS_FLAGS_HI:               reply_byte = REPLY_FLAGS;
      POS_ANCNT_LO:               reply_byte = 8'h01;
      POS_LABEL:                  reply_byte = LABEL_LEN;
      [POS_NAME_LO:POS_NAME_HI]:  reply_byte = ram_rdata;
      POS_QTYPE_LO:               reply_byte = QTYPE_NB[7:0];
      POS_CLASS_LO:               reply_byte = 8'h01;
      POS_TTL_1:                  reply_byte = TTL_1;
      POS_TTL_2:                  reply_byte = TTL_2;
      POS_TTL_3:                  reply_byte = TTL_3;
      POS_RDLEN_LO:               reply_byte = RDLEN_LO;
      POS_IP_0:                   reply_byte = cfg_ip[31:24];
      POS_IP_1:                   reply_byte = cfg_ip[23:16];
      POS_IP_2:                   reply_byte = cfg_ip[15:8];
      POS_IP_3:                   reply_byte = cfg_ip[7:0];
      default:                    reply_byte = 8'h00;
    endcase
  end

  assign reply_last = (k_r == POS_REPLY_END);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= 6'd0;
      bank_r <= 1'b0;
    end else begin
      k_r    <= k_nxt;
      bank_r <= bank_nxt;
    end
  end

endmodule

// ===== rtl/core/netbios_name_query_responder.sv =====
// Top level of the name query responder: config registers, parser, queue,
// reply generator and name RAM. Depends on nnq_pkg and all nnq_* modules.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------
//   in      | in_push / in_full  | in_data_byte, in_last_byte
//   out     | out_pop / out_empty| out_reply_byte, out_reply_last
//   cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One request byte per cycle while in_full is low; the query check is done on the last byte.
// A matching query queues a 62-byte reply, one byte per cycle while popped.
// Up to two replies are held (two name RAM banks); in_full rises while
// both are held. Synchronous active-low reset; no clearing pass.
module netbios_name_query_responder import nnq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_reply_byte,
  output logic        out_reply_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0]       name_first_r;
  logic [55:0]       name_rest_r;
  logic [3:0]        name_len_r;
  logic [31:0]       ip_r;
  logic              cfg_we;
  logic              in_acc;
  nnq_cmd_t          cmd;
  nnq_wr_t           wr;
  logic              req_empty;
  logic              done;
  logic [15:0]       head_tid;
  logic [RAM_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_acc    = in_push && !in_full;
  assign out_empty = req_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_first_r <= 64'h0;
      name_rest_r  <= 56'h0;
      name_len_r   <= 4'h0;
      ip_r         <= 32'h0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NAME_FIRST: name_first_r <= cfg_data;
        CFG_NAME_REST:  name_rest_r  <= cfg_data[55:0];
        CFG_NAME_LEN:   name_len_r   <= cfg_data[3:0];
        CFG_IP_ADDR:    ip_r         <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  nnq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (in_acc),
    .data_byte    (in_data_byte),
    .last_byte    (in_last_byte),
    .cfg_name     ({name_rest_r, name_first_r}),
    .cfg_name_len (name_len_r),
    .cfg_ip       (ip_r),
    .cmd          (cmd),
    .wr           (wr)
  );

  nnq_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .pop      (done),
    .head_tid (head_tid),
    .full     (in_full),
    .empty    (req_empty)
  );

  nnq_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nnq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_empty  (req_empty),
    .head_tid   (head_tid),
    .cfg_ip     (ip_r),
    .ram_rdata  (ram_rdata),
    .out_pop    (out_pop),
    .ram_raddr  (ram_raddr),
    .done       (done),
    .reply_byte (out_reply_byte),
    .reply_last (out_reply_last)
  );

endmodule

// ===== rtl/core/nnq_checker.sv =====
// Port-level checks of the responder, bound to the top level.
// Depends only on the top level's ports.
module nnq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_reply_byte,
  input logic       out_reply_last
);

  logic [5:0] seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 6'd0;
    end else if (out_pop && !out_empty) begin
      seen_r <= out_reply_last ? 6'd0 : seen_r + 6'd1;
    end
  end

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_reply_last == (seen_r == 6'd61)))
    else $error("reply_last not on byte 61");

  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("input stalled with no reply pending");

  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_reply_last) |=> !out_empty)
    else $error("gap inside a reply");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_reply_byte)))
    else $error("stalled reply byte changed");

endmodule

bind netbios_name_query_responder nnq_checker u_chk (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for netbios_name_query_responder: byte-stream NBNS queries in,
// predicted 62-byte replies compared byte by byte on the result side.
// Depends on nnq_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module testbench;
  import nnq_pkg::*;

  localparam int SETTLE      = 32;
  localparam int HOLD_CYCLES = 400;
  localparam int WD_LIMIT    = 4000;
  localparam int REPLY_LEN   = 62;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_t;

  typedef enum logic [3:0] {
    Q_GOOD, Q_MIN, Q_SHORT, Q_LONG, Q_QR, Q_OPCODE, Q_FLAGS_OTHER, Q_QD_ZERO,
    Q_QD_MAX, Q_LABEL_BAD, Q_QTYPE_BAD, Q_CASE, Q_OTHER_NAME, Q_ALIAS, Q_SINGLE, Q_NOISE
  } query_kind_e;

  typedef enum logic [2:0] {
    CP_KEEP, CP_WORD, CP_ONES, CP_ZEROS, CP_ONE_CHAR, CP_NO_ADDR, CP_NAME_OFF
  } cfg_pick_e;

  typedef enum logic [1:0] {CHK_MODEL, CHK_SILENT} check_e;

  typedef struct packed {
    cfg_pick_e   cfg;
    query_kind_e kind;
    check_e      chk;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_pop = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [7:0]  cfg_index = 8'h00;
  logic [63:0] cfg_data = 64'h0;
  logic        in_full;
  logic        out_empty;
  logic [7:0]  out_reply_byte;
  logic        out_reply_last;
  logic        cfg_ready;

  netbios_name_query_responder dut (.*);

  always #10 clk = ~clk;

  // shadow of the responder: configuration and parse state
  logic [63:0] reg_first = '0;
  logic [55:0] reg_rest = '0;
  logic [3:0]  reg_len = '0;
  logic [31:0] reg_ip = '0;
  logic [5:0]  nm_count = '0;
  logic [15:0] nm_tid = '0;
  logic [15:0] nm_flags = '0;
  logic [15:0] nm_qdcount = '0;
  logic [7:0]  nm_label = '0;
  logic [15:0] nm_qtype = '0;
  logic [7:0]  nm_name [32];

  reply_t     reply_due [$];
  logic [7:0] dgram [$];
  int         replies_made = 0;
  int         errors = 0;
  int         idle_mode = 2;
  int         rx_hold_req = 0;
  int         rx_hold_seen = 0;
  int         rx_hold_left = 0;
  int         wd_idle = 0;
  reply_t     rx_head;

  plan_row_t plan [22] = '{
    '{CP_KEEP,     Q_GOOD,        CHK_SILENT},  // reset: name length zero
    '{CP_WORD,     Q_GOOD,        CHK_MODEL},
    '{CP_KEEP,     Q_MIN,         CHK_MODEL},
    '{CP_KEEP,     Q_SHORT,       CHK_SILENT},
    '{CP_KEEP,     Q_LONG,        CHK_MODEL},
    '{CP_KEEP,     Q_QR,          CHK_SILENT},
    '{CP_KEEP,     Q_OPCODE,      CHK_SILENT},
    '{CP_KEEP,     Q_FLAGS_OTHER, CHK_MODEL},
    '{CP_KEEP,     Q_QD_ZERO,     CHK_SILENT},
    '{CP_KEEP,     Q_QD_MAX,      CHK_MODEL},
    '{CP_KEEP,     Q_LABEL_BAD,   CHK_SILENT},
    '{CP_KEEP,     Q_QTYPE_BAD,   CHK_SILENT},
    '{CP_KEEP,     Q_CASE,        CHK_MODEL},
    '{CP_KEEP,     Q_OTHER_NAME,  CHK_SILENT},
    '{CP_KEEP,     Q_SINGLE,      CHK_SILENT},
    '{CP_KEEP,     Q_NOISE,       CHK_MODEL},
    '{CP_ONES,     Q_GOOD,        CHK_MODEL},
    '{CP_ZEROS,    Q_GOOD,        CHK_MODEL},
    '{CP_ONE_CHAR, Q_ALIAS,       CHK_MODEL},
    '{CP_NO_ADDR,  Q_GOOD,        CHK_SILENT},
    '{CP_NAME_OFF, Q_GOOD,        CHK_SILENT},
    '{CP_WORD,     Q_ALIAS,       CHK_MODEL}
  };

  initial begin
    for (int i = 0; i < 32; i++) nm_name[i] = 8'h00;
  end

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic [7:0] name_char(input int i);
    return (i < 8) ? reg_first[8*i +: 8] : reg_rest[8*(i-8) +: 8];
  endfunction

  // absorbs one request byte; queues the reply when the query matches and keep is set
  function automatic void track_byte(input logic [7:0] b, input logic last,
                                     input logic keep);
    logic [7:0] raw [16];
    logic [7:0] resp [REPLY_LEN];
    logic [7:0] hi, lo;
    int seen, trimmed;
    if (nm_count < COUNT_MAX) begin
      case (nm_count)
        POS_TID_HI:   nm_tid[15:8] = b;
        POS_TID_LO:   nm_tid[7:0] = b;
        POS_FLAGS_HI: nm_flags[15:8] = b;
        POS_FLAGS_LO: nm_flags[7:0] = b;
        POS_QDCNT_HI: nm_qdcount[15:8] = b;
        POS_QDCNT_LO: nm_qdcount[7:0] = b;
        POS_LABEL:    nm_label = b;
        POS_QTYPE_HI: nm_qtype[15:8] = b;
        POS_QTYPE_LO: nm_qtype[7:0] = b;
        default: begin
          if (nm_count >= POS_NAME_LO && nm_count <= POS_NAME_HI)
            nm_name[nm_count - POS_NAME_LO] = b;
        end
      endcase
      nm_count++;
    end
    if (!last) return;
    seen = nm_count;
    nm_count = '0;
    if (seen < MIN_QUERY_LEN || (nm_flags & (FLAG_QR | FLAG_OPCODE)) != 0 ||
        nm_qdcount == 0 || nm_label != LABEL_LEN || nm_qtype != QTYPE_NB ||
        reg_len == 0 || reg_ip == 0) return;
    for (int i = 0; i < 16; i++) begin
      hi = nm_name[2*i] - ENC_BASE;
      lo = nm_name[2*i+1] - ENC_BASE;
      raw[i] = {hi[3:0], lo[3:0]};
    end
    trimmed = NAME_CHARS;
    while (trimmed > 0 && raw[trimmed-1] == CHAR_SPACE) trimmed--;
    if (trimmed != reg_len) return;
    for (int i = 0; i < trimmed; i++)
      if (upcase(raw[i]) != upcase(name_char(i))) return;
    for (int k = 0; k < REPLY_LEN; k++) resp[k] = 8'h00;
    resp[POS_TID_HI]   = nm_tid[15:8];
    resp[POS_TID_LO]   = nm_tid[7:0];
    resp[POS_FLAGS_HI] = REPLY_FLAGS;
    resp[POS_ANCNT_LO] = 8'h01;
    resp[POS_LABEL]    = LABEL_LEN;
    for (int k = 0; k < NAME_BYTES; k++) resp[POS_NAME_LO + k] = nm_name[k];
    resp[POS_QTYPE_LO] = QTYPE_NB[7:0];
    resp[POS_CLASS_LO] = 8'h01;
    resp[POS_TTL_1]    = TTL_1;
    resp[POS_TTL_2]    = TTL_2;
    resp[POS_TTL_3]    = TTL_3;
    resp[POS_RDLEN_LO] = RDLEN_LO;
    resp[POS_IP_0]     = reg_ip[31:24];
    resp[POS_IP_1]     = reg_ip[23:16];
    resp[POS_IP_2]     = reg_ip[15:8];
    resp[POS_IP_3]     = reg_ip[7:0];
    replies_made++;
    if (keep)
      for (int k = 0; k < REPLY_LEN; k++)
        reply_due.push_back('{data: resp[k], last: (k == POS_REPLY_END)});
  endfunction

  function automatic logic [119:0] random_name(input logic [3:0] len);
    logic [119:0] v;
    v = 120'({$urandom, $urandom, $urandom, $urandom});
    if (len != 0 && v[8*(len-1) +: 8] == CHAR_SPACE) v[8*(len-1) +: 8] = ENC_BASE;
    return v;
  endfunction

  // builds one datagram in dgram from the current name and the given defect
  task automatic build_dgram(input query_kind_e kind);
    logic [15:0] tid, flags, qd, qtype;
    logic [7:0]  label, ch, hi_twist, lo_twist;
    logic [7:0]  raw [16];
    logic [7:0]  enc [32];
    int          n_len, idx;
    logic        twist_on, flip;
    tid = 16'($urandom);
    flags = 16'($urandom) & 16'h07ff;
    qd = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 16'hffff)) : 16'h0001;
    label = LABEL_LEN;
    qtype = QTYPE_NB;
    twist_on = (kind == Q_ALIAS) || ($urandom_range(0, 7) == 0);
    n_len = ($urandom_range(0, 3) == 0) ? 50 + $urandom_range(1, 12) : 50;
    for (int i = 0; i < 15; i++) begin
      ch = (i < reg_len) ? name_char(i) : CHAR_SPACE;
      flip = (kind == Q_CASE) || ($urandom_range(0, 1) == 1);
      if (flip && ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z"))) ch ^= 8'h20;
      raw[i] = ch;
    end
    raw[15] = 8'($urandom);
    case (kind)
      Q_MIN:         n_len = 50;
      Q_SHORT:       n_len = 49;
      Q_LONG:        n_len = $urandom_range(64, 100);
      Q_QR:          flags |= FLAG_QR;
      Q_OPCODE:      flags |= 16'($urandom_range(1, 15) << 11);
      Q_FLAGS_OTHER: flags = 16'h07ff;
      Q_QD_ZERO:     qd = 16'h0000;
      Q_QD_MAX:      qd = 16'hffff;
      Q_LABEL_BAD:   label ^= 8'(1 << $urandom_range(0, 7));
      Q_QTYPE_BAD:   qtype ^= 16'(1 << $urandom_range(0, 15));
      Q_OTHER_NAME: begin
        idx = $urandom_range(0, 14);
        raw[idx] ^= 8'h01;
      end
      Q_SINGLE:      n_len = 1;
      Q_NOISE:       n_len = $urandom_range(1, 80);
      default: ;
    endcase
    for (int i = 0; i < 16; i++) begin
      hi_twist = twist_on ? 8'($urandom_range(0, 15) << 4) : 8'h00;
      lo_twist = twist_on ? 8'($urandom_range(0, 15) << 4) : 8'h00;
      enc[2*i]   = ENC_BASE + {4'h0, raw[i][7:4]} + hi_twist;
      enc[2*i+1] = ENC_BASE + {4'h0, raw[i][3:0]} + lo_twist;
    end
    dgram.delete();
    for (int p = 0; p < n_len; p++) begin
      if (kind == Q_NOISE) dgram.push_back(8'($urandom));
      else begin
        case (p)
          POS_TID_HI:   dgram.push_back(tid[15:8]);
          POS_TID_LO:   dgram.push_back(tid[7:0]);
          POS_FLAGS_HI: dgram.push_back(flags[15:8]);
          POS_FLAGS_LO: dgram.push_back(flags[7:0]);
          POS_QDCNT_HI: dgram.push_back(qd[15:8]);
          POS_QDCNT_LO: dgram.push_back(qd[7:0]);
          POS_LABEL:    dgram.push_back(label);
          45:           dgram.push_back(8'h00);
          POS_QTYPE_HI: dgram.push_back(qtype[15:8]);
          POS_QTYPE_LO: dgram.push_back(qtype[7:0]);
          48:           dgram.push_back(8'h00);
          POS_CLASS_LO: dgram.push_back(8'h01);
          default: begin
            if (p >= POS_NAME_LO && p <= POS_NAME_HI) dgram.push_back(enc[p - POS_NAME_LO]);
            else dgram.push_back(8'($urandom));
          end
        endcase
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input logic keep);
    int idle_pct;
    idle_pct = (idle_mode == 0) ? 17 : (idle_mode == 1) ? 85 : 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    track_byte(b, last, keep);
  endtask

  task automatic send_dgram(input logic keep);
    for (int i = 0; i < dgram.size(); i++) send_byte(dgram[i], i == dgram.size() - 1, keep);
  endtask

  // sender pauses until every queued reply has come out
  task automatic drain();
    in_push <= 1'b0;
    while (reply_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_NAME_FIRST: reg_first = val;
      CFG_NAME_REST:  reg_rest = val[55:0];
      CFG_NAME_LEN:   reg_len = val[3:0];
      CFG_IP_ADDR:    reg_ip = val[31:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [119:0] chars, input logic [3:0] len,
                            input logic [31:0] ip);
    write_reg(CFG_NAME_FIRST, chars[63:0]);
    write_reg(CFG_NAME_REST, {8'($urandom), chars[119:64]});
    write_reg(CFG_NAME_LEN, {60'({$urandom, $urandom}), len});
    write_reg(CFG_IP_ADDR, {$urandom, ip});
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_pick(input cfg_pick_e pick);
    logic [119:0] chars;
    drain();
    case (pick)
      CP_WORD: begin
        chars = random_name(4'd0);
        chars[47:0] = "7-edoN";  // "Node-7", char 0 in the low byte
        set_config(chars, 4'd6, 32'hc0a8_0164);
      end
      CP_ONES:     set_config({120{1'b1}}, 4'd15, 32'hffff_ffff);
      CP_ZEROS:    set_config('0, 4'd15, 32'h0000_0001);
      CP_ONE_CHAR: set_config(random_name(4'd1), 4'd1, 32'h0a00_0001);
      CP_NO_ADDR:  set_config({reg_rest, reg_first}, reg_len, 32'h0);
      CP_NAME_OFF: set_config({reg_rest, reg_first}, 4'd0, 32'h0a00_0002);
      default: ;
    endcase
  endtask

  // result side: check each popped byte, then pick the next pop
  always @(posedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else begin
      if (out_pop && !out_empty) begin
        if (reply_due.size() == 0) begin
          $display("%0t unexpected reply byte: expected none, got %02h last %0b",
                   $time, out_reply_byte, out_reply_last);
          errors++;
        end else begin
          rx_head = reply_due.pop_front();
          if (out_reply_byte !== rx_head.data) begin
            $display("%0t reply_byte mismatch: expected %02h, got %02h",
                     $time, rx_head.data, out_reply_byte);
            errors++;
          end
          if (out_reply_last !== rx_head.last) begin
            $display("%0t reply_last mismatch: expected %0b, got %0b",
                     $time, rx_head.last, out_reply_last);
            errors++;
          end
        end
      end
      if (rx_hold_req != rx_hold_seen) begin
        rx_hold_seen = rx_hold_req;
        rx_hold_left = HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= $urandom_range(0, 99) >= ((idle_mode == 0) ? 85 : (idle_mode == 1) ? 17 : 0);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      wd_idle <= 0;
    else
      wd_idle <= wd_idle + 1;
    if (wd_idle >= WD_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int          seg, seg_start;
    logic [3:0]  len;
    logic [31:0] ip;
    query_kind_e kind;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_mode = 2;
    foreach (plan[i]) begin
      if (plan[i].cfg != CP_KEEP) apply_pick(plan[i].cfg);
      build_dgram(plan[i].kind);
      send_dgram(plan[i].chk == CHK_MODEL);
    end

    // long receiver stall while queries keep coming, then a full drain
    drain();
    rx_hold_req++;
    for (int i = 0; i < 3; i++) begin
      build_dgram(Q_GOOD);
      send_dgram(1'b1);
    end
    drain();

    for (seg = 0; seg < 3; seg++) begin
      drain();
      idle_mode = seg;
      len = (seg == 0) ? 4'd15 : (seg == 1) ? 4'd1 : 4'($urandom_range(1, 15));
      ip = (seg == 0) ? 32'hffff_ffff : (seg == 1) ? 32'h0000_0001 : ($urandom | 32'h1);
      set_config(random_name(len), len, ip);
      seg_start = replies_made;
      while (replies_made == seg_start) begin
        kind = ($urandom_range(0, 99) < 65) ? Q_GOOD : query_kind_e'($urandom_range(1, 15));
        build_dgram(kind);
        send_dgram(1'b1);
      end
    end

    drain();
    if (errors == 0 && reply_due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/nnq_pkg.sv
rtl/core/nnq_ram.sv
rtl/core/nnq_front.sv
rtl/core/nnq_fifo.sv
rtl/core/nnq_back.sv
rtl/core/netbios_name_query_responder.sv
rtl/core/nnq_checker.sv
bench/testbench.sv
